// ----- hdl/qbt_pkg.sv -----
// Shared types, constants and arithmetic helpers for the quadratic Bezier
// tessellator. No dependencies.
package qbt_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int SEG_W       = 6;
   localparam int COORD_W     = 16;
   localparam int DIST_W      = 17;
   localparam int T_W         = 17;   // t runs 0..65536
   localparam int REM_W       = CNT_W + 1;
   localparam int DIV_STEPS   = T_W;
   localparam int SQRT_STEPS  = 17;
   localparam int SQ_W        = 34;
   localparam int STEP_W      = 5;
   localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(50);

   localparam logic OP_TESS  = 1'b0;
   localparam logic OP_QUERY = 1'b1;
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_DIST   = 1'b1;

   typedef struct packed {
      logic                       opcode;
      logic signed [COORD_W-1:0]  start_x;
      logic signed [COORD_W-1:0]  start_y;
      logic signed [COORD_W-1:0]  ctrl_x;
      logic signed [COORD_W-1:0]  ctrl_y;
      logic signed [COORD_W-1:0]  end_x;
      logic signed [COORD_W-1:0]  end_y;
      logic signed [COORD_W-1:0]  query_x;
      logic signed [COORD_W-1:0]  query_y;
   } qbt_job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_LERP0,
      ST_LERP1,
      ST_LERP2,
      ST_T_EMIT,
      ST_Q_RD,
      ST_Q_SQ,
      ST_Q_MIN,
      ST_Q_SQRT,
      ST_Q_EMIT
   } qbt_state_type;

   // a + floor((b-a)*t/65536); arithmetic shift gives the floor
   function automatic logic signed [COORD_W-1:0] lerp(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input logic [T_W-1:0]            t);
      logic signed [COORD_W:0]     d;
      logic signed [COORD_W+T_W+1:0] p;
      logic signed [COORD_W+T_W+1:0] q;
      logic signed [COORD_W+T_W+1:0] s;
      d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
      p = d * $signed({1'b0, t});
      q = p >>> 16;
      s = q + (COORD_W+T_W+2)'(a);
      return s[COORD_W-1:0];
   endfunction

endpackage

// ----- hdl/qbt_front.sv -----
// Front end: accepts request transactions and queues them for the back end.
// Depends on qbt_pkg.
module qbt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qbt_pkg::qbt_job_type req_job,
   output logic                job_valid,
   input  logic                job_ready,
   output qbt_pkg::qbt_job_type job
);
   import qbt_pkg::*;

   qbt_job_type slot_ff [2];
   qbt_job_type slot_in [2];
   logic [1:0]  fill_ff, fill_in;
   logic        push, pop;

   assign req_ready = (fill_ff != 2'd2);
   assign job_valid = (fill_ff != 2'd0);
   assign job       = slot_ff[0];
   assign push      = req_valid && req_ready;
   assign pop       = job_valid && job_ready;

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         if ((pop && fill_ff == 2'd1) || fill_ff == 2'd0) begin
            slot_in[0] = req_job;
         end else if (pop) begin
            slot_in[1] = req_job;
         end else begin
            slot_in[1] = req_job;
         end
      end
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

// ----- hdl/qbt_back.sv -----
// Back end: tessellation sequencer, sample store, nearest-sample scan,
// integer square root and the result register. Depends on qbt_pkg.
module qbt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [qbt_pkg::SEG_W-1:0]  segments,
   input  logic                       job_valid,
   output logic                       job_ready,
   input  qbt_pkg::qbt_job_type       job,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_kind,
   output logic signed [qbt_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [qbt_pkg::COORD_W-1:0] rsp_point_y,
   output logic [qbt_pkg::DIST_W-1:0] rsp_distance,
   output logic                       rsp_no_curve,
   output logic                       rsp_last
);
   import qbt_pkg::*;

   qbt_state_type state_ff, state_in;
   qbt_job_type   job_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  n_ff, n_c;
   logic [CNT_W-1:0]  i_ff;
   logic [STEP_W-1:0] it_ff;
   logic [REM_W-1:0]  rem_ff, rem_sh;
   logic [T_W-1:0]    quot_ff;
   logic [T_W-1:0]    t_ff;
   logic [REM_W-1:0]  r_ff, r_sum;
   logic signed [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff, px_ff, py_ff;
   logic signed [COORD_W-1:0] la_x, lb_x, la_y, lb_y, lr_x, lr_y;
   logic [31:0]       sqx_ff, sqy_ff;
   logic [SQ_W-1:0]   best_ff, d2, best_new;
   logic [SQ_W-1:0]   v_ff, res_ff, bit_ff, trial;
   logic [31:0]       mem [MAX_SAMPLES];
   logic [31:0]       rd_ff;
   logic signed [COORD_W:0]   dx, dy;
   logic signed [2*COORD_W+1:0] px2, py2;
   logic              out_free, mem_we, last_smp, last_scan;
   logic [SEG_W-1:0]  seg_nz;
   logic              rsp_valid_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign last_smp  = (i_ff == n_ff);
   assign last_scan = (i_ff == count_ff - CNT_W'(1));

   // effective segment count: zero means one, capped to fit the store
   always_comb begin
      seg_nz = (segments == '0) ? SEG_W'(1) : segments;
      if (int'(seg_nz) > MAX_SAMPLES - 1) begin
         n_c = CNT_W'(MAX_SAMPLES - 1);
      end else begin
         n_c = CNT_W'(seg_nz);
      end
   end

   // shared lerp units, one per axis
   always_comb begin
      case (state_ff)
         ST_LERP0: begin
            la_x = job_ff.start_x; lb_x = job_ff.ctrl_x;
            la_y = job_ff.start_y; lb_y = job_ff.ctrl_y;
         end
         ST_LERP1: begin
            la_x = job_ff.ctrl_x;  lb_x = job_ff.end_x;
            la_y = job_ff.ctrl_y;  lb_y = job_ff.end_y;
         end
         default: begin
            la_x = ax_ff; lb_x = bx_ff;
            la_y = ay_ff; lb_y = by_ff;
         end
      endcase
      lr_x = lerp(la_x, lb_x, t_ff);
      lr_y = lerp(la_y, lb_y, t_ff);
   end

   always_comb begin
      rem_sh   = {rem_ff[REM_W-2:0], (it_ff == STEP_W'(DIV_STEPS - 1))};
      r_sum    = r_ff + rem_ff;
      dx       = $signed({rd_ff[15], rd_ff[15:0]})  - $signed({job_ff.query_x[15], job_ff.query_x});
      dy       = $signed({rd_ff[31], rd_ff[31:16]}) - $signed({job_ff.query_y[15], job_ff.query_y});
      px2      = dx * dx;
      py2      = dy * dy;
      d2       = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
      best_new = (d2 < best_ff) ? d2 : best_ff;
      trial    = res_ff + bit_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               if (job.opcode == OP_TESS) begin
                  state_in = ST_DIV;
               end else if (count_ff == '0) begin
                  state_in = ST_Q_EMIT;
               end else begin
                  state_in = ST_Q_RD;
               end
            end
         end
         ST_DIV:    if (it_ff == '0) state_in = ST_LERP0;
         ST_LERP0:  state_in = ST_LERP1;
         ST_LERP1:  state_in = ST_LERP2;
         ST_LERP2:  state_in = ST_T_EMIT;
         ST_T_EMIT: if (out_free) state_in = last_smp ? ST_IDLE : ST_LERP0;
         ST_Q_RD:   state_in = ST_Q_SQ;
         ST_Q_SQ:   state_in = ST_Q_MIN;
         ST_Q_MIN:  state_in = last_scan ? ST_Q_SQRT : ST_Q_RD;
         ST_Q_SQRT: if (it_ff == '0) state_in = ST_Q_EMIT;
         ST_Q_EMIT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      job_ready = 1'b0;
      mem_we    = 1'b0;
      case (state_ff)
         ST_IDLE:   job_ready = 1'b1;
         ST_T_EMIT: mem_we    = out_free;
         default: begin
            job_ready = 1'b0;
            mem_we    = 1'b0;
         end
      endcase
   end

   // sample store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[i_ff[ADDR_W-1:0]] <= {py_ff, px_ff};
      end
      rd_ff <= mem[i_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            job_ff  <= job;
            n_ff    <= n_c;
            it_ff   <= STEP_W'(DIV_STEPS - 1);
            rem_ff  <= '0;
            quot_ff <= '0;
            i_ff    <= '0;
            t_ff    <= '0;
            r_ff    <= '0;
            best_ff <= '1;
         end
         ST_DIV: begin
            // restoring division 65536 / n, one quotient bit a cycle
            if (rem_sh >= REM_W'(n_ff)) begin
               rem_ff  <= rem_sh - REM_W'(n_ff);
               quot_ff <= {quot_ff[T_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               quot_ff <= {quot_ff[T_W-2:0], 1'b0};
            end
            it_ff <= it_ff - STEP_W'(1);
         end
         ST_LERP0: begin
            ax_ff <= lr_x;
            ay_ff <= lr_y;
         end
         ST_LERP1: begin
            bx_ff <= lr_x;
            by_ff <= lr_y;
         end
         ST_LERP2: begin
            px_ff <= lr_x;
            py_ff <= lr_y;
         end
         ST_T_EMIT: begin
            if (out_free && !last_smp) begin
               i_ff <= i_ff + CNT_W'(1);
               // t += 65536/n with the remainder carried
               if (r_sum >= REM_W'(n_ff)) begin
                  r_ff <= r_sum - REM_W'(n_ff);
                  t_ff <= t_ff + quot_ff + T_W'(1);
               end else begin
                  r_ff <= r_sum;
                  t_ff <= t_ff + quot_ff;
               end
            end
         end
         ST_Q_SQ: begin
            sqx_ff <= px2[31:0];
            sqy_ff <= py2[31:0];
         end
         ST_Q_MIN: begin
            best_ff <= best_new;
            i_ff    <= i_ff + CNT_W'(1);
            v_ff    <= best_new;
            res_ff  <= '0;
            bit_ff  <= SQ_W'(1) << 32;
            it_ff   <= STEP_W'(SQRT_STEPS - 1);
         end
         ST_Q_SQRT: begin
            if (v_ff >= trial) begin
               v_ff   <= v_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            it_ff  <= it_ff - STEP_W'(1);
         end
         default: begin
            it_ff <= it_ff;
         end
      endcase

      if (state_ff == ST_T_EMIT && out_free) begin
         rsp_kind     <= KIND_SAMPLE;
         rsp_point_x  <= px_ff;
         rsp_point_y  <= py_ff;
         rsp_distance <= '0;
         rsp_no_curve <= 1'b0;
         rsp_last     <= last_smp;
      end else if (state_ff == ST_Q_EMIT && out_free) begin
         rsp_kind     <= KIND_DIST;
         rsp_point_x  <= '0;
         rsp_point_y  <= '0;
         rsp_distance <= (count_ff == '0) ? '0 : res_ff[DIST_W-1:0];
         rsp_no_curve <= (count_ff == '0);
         rsp_last     <= 1'b1;
      end

      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_T_EMIT && out_free && last_smp) begin
            count_ff <= n_ff + CNT_W'(1);
         end
         if ((state_ff == ST_T_EMIT || state_ff == ST_Q_EMIT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- hdl/quad_bezier_tessellate_nearest.sv -----
// Tessellate: a division, then three lerp steps and an emit for each sample; query:
// a store scan, then a bit-pair square root.
// One transaction is worked at a time in the back end; two more may queue.
// Synchronous active-high reset clears the queue, sequencer, result slot and the
// sample count (no curve); segments resets to 50. Store contents are not cleared.
// Depends on qbt_pkg, qbt_front, qbt_back.
module quad_bezier_tessellate_nearest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic signed [15:0] req_ctrl_x,
   input  logic signed [15:0] req_ctrl_y,
   input  logic signed [15:0] req_end_x,
   input  logic signed [15:0] req_end_y,
   input  logic signed [15:0] req_query_x,
   input  logic signed [15:0] req_query_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic signed [15:0] rsp_point_x,
   output logic signed [15:0] rsp_point_y,
   output logic [16:0] rsp_distance,
   output logic        rsp_no_curve,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata
);
   import qbt_pkg::*;

   qbt_job_type      req_job, job;
   logic             job_valid, job_ready;
   logic [SEG_W-1:0] segments_ff;

   // segment count register; the user must write it only while idle (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         segments_ff <= SEG_RESET;
      end else if (csr_we) begin
         segments_ff <= csr_wdata;
      end
   end

   always_comb begin
      req_job.opcode  = req_opcode;
      req_job.start_x = req_start_x;
      req_job.start_y = req_start_y;
      req_job.ctrl_x  = req_ctrl_x;
      req_job.ctrl_y  = req_ctrl_y;
      req_job.end_x   = req_end_x;
      req_job.end_y   = req_end_y;
      req_job.query_x = req_query_x;
      req_job.query_y = req_query_y;
   end

   // front: accept and queue transactions
   qbt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_job   (req_job),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   // back: tessellate or scan, then register the result
   qbt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .segments     (segments_ff),
      .job_valid    (job_valid),
      .job_ready    (job_ready),
      .job          (job),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_point_x  (rsp_point_x),
      .rsp_point_y  (rsp_point_y),
      .rsp_distance (rsp_distance),
      .rsp_no_curve (rsp_no_curve),
      .rsp_last     (rsp_last)
   );

   // a distance result is always the only, hence last, result
   a_dist_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DIST |-> rsp_last)
      else $error("distance result without last");

   // samples carry no distance and never flag a missing curve
   a_sample_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SAMPLE |-> rsp_distance == '0 && !rsp_no_curve)
      else $error("sample result with distance fields set");

   // no_curve only on a distance result with zero distance
   a_nocurve: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_curve |-> rsp_kind == KIND_DIST && rsp_distance == '0)
      else $error("bad no_curve result");

endmodule

// ----- tb/quad_bezier_tessellate_nearest_tb.sv -----
// Testbench for quad_bezier_tessellate_nearest: directed and random curves and
// distance queries, checked against an in-bench tessellation/distance predictor.
// Depends on qbt_pkg and the quad_bezier_tessellate_nearest RTL.
module quad_bezier_tessellate_nearest_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qbt_pkg::*;

   typedef struct {
      logic              kind;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic [16:0]       distance;
      logic              no_curve;
      logic              last;
   } sample_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = 1'b0;
   logic signed [15:0] req_start_x = '0, req_start_y = '0, req_ctrl_x = '0;
   logic signed [15:0] req_ctrl_y = '0, req_end_x = '0, req_end_y = '0;
   logic signed [15:0] req_query_x = '0, req_query_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_kind;
   logic signed [15:0] rsp_point_x, rsp_point_y;
   logic [16:0] rsp_distance;
   logic rsp_no_curve, rsp_last;
   logic csr_we = 1'b0;
   logic [5:0] csr_wdata = '0;

   quad_bezier_tessellate_nearest u_top (.*);

   always #6 clock = ~clock;

   // pending transactions for the driver, expected results for the monitor
   qbt_job_type job_q[$];
   sample_rsp_type expected_rsp_q[$];

   // predictor state
   logic [5:0]  pred_segments;
   logic [31:0] pred_store[MAX_SAMPLES];
   int unsigned pred_count;

   int unsigned errors = 0;
   int unsigned idle_cycles = 0;
   bit          req_no_idle = 1'b0;
   bit          rsp_no_idle = 1'b0;
   bit          rsp_hold = 1'b0;

   function automatic void enqueue_job(qbt_job_type j);
      job_q.insert(job_q.size(), j);
   endfunction

   function automatic void enqueue_rsp(sample_rsp_type r);
      expected_rsp_q.insert(expected_rsp_q.size(), r);
   endfunction

   // a + floor((b-a)*t/65536)
   function automatic int lerp_floor(int a, int b, longint t);
      longint p;
      p = longint'(b - a) * t;
      return a + int'(p >>> 16);
   endfunction

   function automatic int sx16(logic [15:0] v);
      return int'($signed(v));
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   // work out every result of one accepted transaction
   task automatic predict_curve_job(qbt_job_type j);
      int unsigned n;
      longint t;
      int ax, ay, bx, by, px, py;
      sample_rsp_type r;
      longint unsigned best, d2;
      longint dx, dy;
      if (j.opcode == OP_TESS) begin
         n = pred_segments;
         if (n == 0) n = 1;
         if (n > MAX_SAMPLES - 1) n = MAX_SAMPLES - 1;
         for (int unsigned i = 0; i <= n; i++) begin
            t  = longint'((i * 65536) / n);
            ax = lerp_floor(j.start_x, j.ctrl_x, t);
            ay = lerp_floor(j.start_y, j.ctrl_y, t);
            bx = lerp_floor(j.ctrl_x, j.end_x, t);
            by = lerp_floor(j.ctrl_y, j.end_y, t);
            px = lerp_floor(ax, bx, t);
            py = lerp_floor(ay, by, t);
            pred_store[i] = {py[15:0], px[15:0]};
            r.kind = KIND_SAMPLE;
            r.point_x = px[15:0];
            r.point_y = py[15:0];
            r.distance = '0;
            r.no_curve = 1'b0;
            r.last = (i == n);
            enqueue_rsp(r);
         end
         pred_count = n + 1;
      end else begin
         r.kind = KIND_DIST;
         r.point_x = '0;
         r.point_y = '0;
         r.last = 1'b1;
         if (pred_count == 0) begin
            r.distance = '0;
            r.no_curve = 1'b1;
         end else begin
            best = '1;
            for (int unsigned i = 0; i < pred_count; i++) begin
               dx = sx16(pred_store[i][15:0]) - sx16(j.query_x);
               dy = sx16(pred_store[i][31:16]) - sx16(j.query_y);
               d2 = longint'(dx * dx) + longint'(dy * dy);
               if (d2 < best) best = d2;
            end
            r.distance = 17'(floor_sqrt(best));
            r.no_curve = 1'b0;
         end
         enqueue_rsp(r);
      end
   endtask

   // driver: offers the next pending transaction, idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_curve_job({req_opcode, req_start_x, req_start_y, req_ctrl_x,
                               req_ctrl_y, req_end_x, req_end_y, req_query_x,
                               req_query_y});
         end
         if ((!req_valid || req_ready) && job_q.size() != 0 &&
             (req_no_idle || $urandom_range(99) >= 30)) begin
            qbt_job_type j;
            j = job_q.pop_front();
            req_valid   <= 1'b1;
            req_opcode  <= j.opcode;
            req_start_x <= j.start_x;
            req_start_y <= j.start_y;
            req_ctrl_x  <= j.ctrl_x;
            req_ctrl_y  <= j.ctrl_y;
            req_end_x   <= j.end_x;
            req_end_y   <= j.end_y;
            req_query_x <= j.query_x;
            req_query_y <= j.query_y;
         end else if (req_valid && req_ready) begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: random back-pressure, field-by-field compare against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               sample_rsp_type e;
               e = expected_rsp_q.pop_front();
               if (rsp_kind !== e.kind) begin
                  $error("kind exp %0d got %0d", e.kind, rsp_kind); errors++;
               end
               if (rsp_point_x !== e.point_x) begin
                  $error("point_x exp %0d got %0d", e.point_x, rsp_point_x); errors++;
               end
               if (rsp_point_y !== e.point_y) begin
                  $error("point_y exp %0d got %0d", e.point_y, rsp_point_y); errors++;
               end
               if (rsp_distance !== e.distance) begin
                  $error("distance exp %0d got %0d", e.distance, rsp_distance); errors++;
               end
               if (rsp_no_curve !== e.no_curve) begin
                  $error("no_curve exp %0d got %0d", e.no_curve, rsp_no_curve); errors++;
               end
               if (rsp_last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_last); errors++;
               end
            end
         end
         rsp_ready <= !rsp_hold && (rsp_no_idle || $urandom_range(99) >= 30);
      end
   end

   // watchdog: cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAIL quad_bezier_tessellate_nearest");
         $finish;
      end
   end

   function automatic qbt_job_type rand_job(bit op);
      qbt_job_type j;
      j.opcode  = op;
      j.start_x = 16'($urandom);
      j.start_y = 16'($urandom);
      j.ctrl_x  = 16'($urandom);
      j.ctrl_y  = 16'($urandom);
      j.end_x   = 16'($urandom);
      j.end_y   = 16'($urandom);
      j.query_x = 16'($urandom);
      j.query_y = 16'($urandom);
      // one time in three, small start_x, end_y and query_x so queries land closer
      if ($urandom_range(2) == 0) begin
         j.start_x = 16'($signed(12'($urandom)));
         j.end_y   = 16'($signed(12'($urandom)));
         j.query_x = 16'($signed(12'($urandom)));
      end
      return j;
   endfunction

   function automatic qbt_job_type fixed_job(bit op, logic [15:0] v);
      qbt_job_type j;
      j = '{op, v, v, ~v, ~v, v, ~v, v, ~v};
      return j;
   endfunction

   // wait until the queue has drained and every result is in, then let the block settle
   task automatic drain_all();
      @(negedge clock);
      while (job_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(negedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_segments(logic [5:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      pred_segments = v;
   endtask

   initial begin
      logic [5:0] seg_pick[] = '{6'd0, 6'd1, 6'd2, 6'd63, 6'd7, 6'd33};
      for (int i = 0; i < MAX_SAMPLES; i++) pred_store[i] = '0;
      pred_count = 0;
      pred_segments = SEG_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: query with no curve first, then extremes at reset segments
      enqueue_job(rand_job(OP_QUERY));
      enqueue_job(fixed_job(OP_TESS, 16'h7FFF));
      enqueue_job(fixed_job(OP_QUERY, 16'h8000));
      enqueue_job(fixed_job(OP_TESS, 16'h8000));
      enqueue_job(fixed_job(OP_QUERY, 16'h7FFF));
      enqueue_job(fixed_job(OP_TESS, 16'h0000));
      enqueue_job(fixed_job(OP_QUERY, 16'hFFFF));
      drain_all();

      // zero segments (taken as one), maximum; query after a segments change
      write_segments(6'd0);
      enqueue_job(fixed_job(OP_TESS, 16'h1234));
      enqueue_job(fixed_job(OP_QUERY, 16'h1234));
      drain_all();
      write_segments(6'd63);
      enqueue_job(fixed_job(OP_QUERY, 16'h0F00));
      enqueue_job(fixed_job(OP_TESS, 16'hFFFF));
      enqueue_job(fixed_job(OP_QUERY, 16'h8000));
      drain_all();

      // long receiver hold-off while the sender keeps offering
      write_segments(6'd4);
      req_no_idle = 1'b1;
      rsp_hold = 1'b1;
      for (int i = 0; i < 8; i++) enqueue_job(rand_job(i[0]));
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
      req_no_idle = 1'b0;
      drain_all();

      // random phases over several segment settings, small counts dominate
      for (int ph = 0; ph < 10; ph++) begin
         if (ph < seg_pick.size()) write_segments(seg_pick[ph]);
         else write_segments(6'($urandom_range(1, 10)));
         req_no_idle = (ph == 4);
         rsp_no_idle = (ph == 4);
         for (int i = 0; i < 20; i++)
            enqueue_job(rand_job($urandom_range(1)));
         drain_all();
      end
      req_no_idle = 1'b0;
      rsp_no_idle = 1'b0;

      // end of run: all stimulus accepted, nothing outstanding
      drain_all();
      if (errors == 0 && expected_rsp_q.size() == 0)
         $display("PASS quad_bezier_tessellate_nearest");
      else
         $display("FAIL quad_bezier_tessellate_nearest");
      $finish;
   end

endmodule
